FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the picker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge out of reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Types and constants shared by the axis picker modules.
// ----------------------------------------------------------------------------
package rap_pkg;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;
    localparam logic [CfgIdxW-1:0] RegMode = 2'd0;
    localparam logic [CfgIdxW-1:0] RegPivX = 2'd1;
    localparam logic [CfgIdxW-1:0] RegPivY = 2'd2;
    localparam logic [CfgIdxW-1:0] RegPivZ = 2'd3;
    localparam logic [1:0] ModeTranslate = 2'd0;
    localparam logic [1:0] AxisNone = 2'd0;
    localparam logic [1:0] AxisX = 2'd1;
    localparam logic [1:0] AxisY = 2'd2;
    localparam logic [1:0] AxisZ = 2'd3;
    // den * 10000 < 2^32 exactly when den is below this bound
    localparam logic [63:0] ParallelLimit = 64'd429497;
    localparam int unsigned Stages = 9;

    // per axis candidate: squared numerator and denominator
    typedef struct packed {
        logic        hit;
        logic [95:0] sq;
        logic [63:0] den;
    } cand_t;
endpackage

FILE: rtl/rap_axis_unit.sv
// ----------------------------------------------------------------------------
// rap_axis_unit
// Distance test of a ray against one axis line, pipelined over five stages.
// ----------------------------------------------------------------------------
module rap_axis_unit (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [32:0] w_p,
    input  logic signed [32:0] w_q,
    input  logic signed [31:0] d_p,
    input  logic signed [31:0] d_q,
    output rap_pkg::cand_t     cand
);
    import rap_pkg::*;

    logic signed [64:0] m1_reg, m2_reg;
    logic        [63:0] dp2_reg, dq2_reg;
    logic signed [66:0] m_reg;
    logic        [63:0] den_reg;
    logic        [47:0] hh_reg, hl_reg, ll_reg;
    logic               big_reg, big2_reg;
    logic        [63:0] den2_reg, den3_reg;
    logic        [95:0] sq_reg;
    cand_t              cand_reg;
    logic [31:0] ap, aq;
    logic [66:0] am;
    logic [100:0] sq25;
    logic         parallel, near;

    assign ap = d_p[31] ? 32'(-d_p) : 32'(d_p);
    assign aq = d_q[31] ? 32'(-d_q) : 32'(d_q);
    assign am = m_reg[66] ? 67'(-m_reg) : 67'(m_reg);

    // a magnitude of 2^48 or more can never be a hit
    assign sq25 = {5'd0, sq_reg} + {2'd0, sq_reg, 3'd0} + {1'd0, sq_reg, 4'd0};
    assign near = !big2_reg && (sq25 < {5'd0, den3_reg, 32'd0});
    assign parallel = den3_reg < ParallelLimit;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg   <= w_p * d_q;
            m2_reg   <= w_q * d_p;
            dp2_reg  <= ap * ap;
            dq2_reg  <= aq * aq;
            m_reg    <= 67'(m1_reg) - 67'(m2_reg);
            den_reg  <= dp2_reg + dq2_reg;
            hh_reg   <= am[47:24] * am[47:24];
            hl_reg   <= am[47:24] * am[23:0];
            ll_reg   <= am[23:0] * am[23:0];
            big_reg  <= |am[66:48];
            den2_reg <= den_reg;
            sq_reg   <= {hh_reg, 48'd0} + {23'd0, hl_reg, 25'd0} + {48'd0, ll_reg};
            big2_reg <= big_reg;
            den3_reg <= den2_reg;
            cand_reg.sq  <= sq_reg;
            cand_reg.den <= den3_reg;
            cand_reg.hit <= !parallel && near;
        end
    end
    assign cand = cand_reg;
endmodule

FILE: rtl/ray_axis_pick_core.sv
// ----------------------------------------------------------------------------
// ray_axis_pick_core
// Picks the translate-gizmo axis nearest to a pick ray.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one ray request per beat (origin x,y,z then
// direction x,y,z, 32-bit signed Q16.16 each). m_axis returns one byte per
// request, picked_axis in bits 1:0 (0 none, 1 X, 2 Y, 3 Z).
// Config registers are written on cfg_we: 0 mode, 1..3 pivot x,y,z.
// The work runs through nine register stages, from the input registers to
// pick_reg, and all stages advance together whenever nothing stalls.
// Throughput is one request per cycle while the receiver does not stall,
// as all three axes and the three pairwise distance compares run in parallel.
// When the receiver stalls, the whole pipeline holds in place;
// s_axis_tready follows m_axis_tready or an empty output slot.
// Reset clears all valid bits, mode to translate and the pivot to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ray_axis_pick_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
    input  logic [191:0]                s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // picked_axis, then zero fill
    output logic [7:0]                  m_axis_tdata,
    input  logic                        cfg_we,
    input  logic [rap_pkg::CfgIdxW-1:0] cfg_addr,
    input  logic [rap_pkg::CfgDataW-1:0] cfg_wdata
);
    import rap_pkg::*;

    logic [1:0] mode_reg;
    logic signed [31:0] piv_reg [3];
    logic [Stages-1:0] vld_reg;
    logic en;
    logic signed [32:0] w_reg [3];
    logic signed [31:0] d_reg [3];
    logic [Stages-2:0] tm_reg;
    cand_t c [3];
    logic [2:0] hit7_reg, hit8_reg;
    logic lt [3];
    logic [1:0] pick_reg, pick_next;

    assign en = !vld_reg[Stages-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[Stages-1];
    assign m_axis_tdata = {6'd0, pick_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ModeTranslate;
            for (int i = 0; i < 3; i++) piv_reg[i] <= '0;
            vld_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    RegMode: mode_reg <= cfg_wdata[1:0];
                    RegPivX: piv_reg[0] <= cfg_wdata;
                    RegPivY: piv_reg[1] <= cfg_wdata;
                    RegPivZ: piv_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (en) vld_reg <= {vld_reg[Stages-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                w_reg[i] <= 33'(signed'(s_axis_tdata[32*i +: 32])) - 33'(piv_reg[i]);
                d_reg[i] <= s_axis_tdata[96+32*i +: 32];
            end
            tm_reg <= {tm_reg[Stages-3:0], mode_reg == ModeTranslate};
            hit7_reg <= {c[2].hit, c[1].hit, c[0].hit};
            hit8_reg <= hit7_reg;
            pick_reg <= pick_next;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        rap_axis_unit u_axis (
            .aclk(aclk), .en(en),
            .w_p(w_reg[(k+1)%3]), .w_q(w_reg[(k+2)%3]),
            .d_p(d_reg[(k+1)%3]), .d_q(d_reg[(k+2)%3]),
            .cand(c[k])
        );
    end

    // pairwise compare: lt is high when axis J lies strictly nearer than axis I
    for (genvar pr = 0; pr < 3; pr++) begin : g_pair
        localparam int J = (pr == 2) ? 2 : pr + 1;
        localparam int I = (pr == 0) ? 0 : pr - 1;
        logic [63:0]  pa_reg [6];
        logic [63:0]  pb_reg [6];
        logic [159:0] sa, sb;
        logic [159:0] prod_a_reg, prod_b_reg;

        always_comb begin
            sa = '0;
            sb = '0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 2; b++) begin
                    sa = sa + (160'(pa_reg[2*a+b]) << (32*(a+b)));
                    sb = sb + (160'(pb_reg[2*a+b]) << (32*(a+b)));
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        pa_reg[2*a+b] <= c[J].sq[32*a +: 32] * c[I].den[32*b +: 32];
                        pb_reg[2*a+b] <= c[I].sq[32*a +: 32] * c[J].den[32*b +: 32];
                    end
                end
                prod_a_reg <= sa;
                prod_b_reg <= sb;
            end
        end

        assign lt[pr] = prod_a_reg < prod_b_reg;
    end

    // nearest hit wins; ties keep the earlier axis; any mode but mode 0 picks none
    always_comb begin
        pick_next = AxisNone;
        if (hit8_reg[0] && !(hit8_reg[1] && lt[0]) && !(hit8_reg[2] && lt[1])) begin
            pick_next = AxisX;
        end else if (hit8_reg[1] && !(hit8_reg[2] && lt[2])) begin
            pick_next = AxisY;
        end else if (hit8_reg[2]) begin
            pick_next = AxisZ;
        end
        if (!tm_reg[Stages-2]) pick_next = AxisNone;
    end

    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(pick_reg))
    `ASSERT_NEXT(a_flow, aclk, aresetn, s_axis_tvalid && s_axis_tready, vld_reg[0])
endmodule

FILE: bench/rap_pick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rap_pick_checker
// Watches the ray and pick channels of the axis picker, tracks the register
// writes, predicts the picked axis of each accepted ray with exact wide
// integer arithmetic and compares it with each accepted pick in order.
// ----------------------------------------------------------------------------
module rap_pick_checker
    import rap_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [191:0]        s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [7:0]          m_axis_tdata,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output int                  errors
);
    logic [1:0]  mode;
    logic [31:0] pivot [3];
    logic [7:0]  pick_queue [$];

    function automatic logic [1:0] pick_axis(logic [191:0] ray);
        logic signed [33:0]  w [3];
        logic signed [33:0]  d [3];
        logic signed [71:0]  m;
        logic signed [143:0] m2;
        logic signed [67:0]  dd;
        logic [255:0] sq, den, best_sq, best_den;
        logic [255:0] two32;
        logic [1:0]   pick;
        bit           have;
        bit           parallel, near;
        int           p, q;
        pick = AxisNone;
        have = 0;
        best_sq = '0;
        best_den = '0;
        two32 = 256'(1) << 32;
        for (int k = 0; k < 3; k++) begin
            w[k] = 34'($signed(ray[32*k +: 32])) - 34'($signed(pivot[k]));
            d[k] = 34'($signed(ray[32*(k+3) +: 32]));
        end
        if (mode == ModeTranslate) begin
            for (int k = 0; k < 3; k++) begin
                p = (k + 1) % 3;
                q = (k + 2) % 3;
                m = 72'(w[p]) * 72'(d[q]) - 72'(w[q]) * 72'(d[p]);
                m2 = 144'(m) * 144'(m);
                dd = 68'(d[p]) * 68'(d[p]) + 68'(d[q]) * 68'(d[q]);
                sq = 256'(unsigned'(m2));
                den = 256'(unsigned'(dd));
                parallel = (den * 256'd10000) < two32;
                near = (sq * 256'd25) < (den << 32);
                if (!parallel && near) begin
                    if (!have || (sq * best_den) < (best_sq * den)) begin
                        have = 1;
                        best_sq = sq;
                        best_den = den;
                        pick = 2'(k + 1);
                    end
                end
            end
        end
        return pick;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode = ModeTranslate;
            for (int k = 0; k < 3; k++) pivot[k] = '0;
            pick_queue.delete();
            errors = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pick_queue.size() == 0) begin
                    $display("%0t: unexpected pick, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else if (pick_queue[0] !== m_axis_tdata) begin
                    $display("%0t: pick mismatch, expected %h, actual %h",
                             $time, pick_queue[0], m_axis_tdata);
                    errors++;
                    void'(pick_queue.pop_front());
                end else begin
                    void'(pick_queue.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pick_queue.push_back({6'b0, pick_axis(s_axis_tdata)});
            if (cfg_we) begin
                case (cfg_addr)
                    RegMode: mode = cfg_wdata[1:0];
                    RegPivX: pivot[0] = cfg_wdata;
                    RegPivY: pivot[1] = cfg_wdata;
                    RegPivZ: pivot[2] = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    function automatic int pending();
        return pick_queue.size();
    endfunction
endmodule

FILE: bench/tb_ray_axis_pick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_axis_pick_core
// Drives pick rays into the axis picker under several mode and pivot
// settings, with random gaps on the ray side and stalls on the pick side.
// Directed rays cover field extremes, hits on each axis, the 0.2 boundary,
// near-parallel and zero directions and the non-translate modes; random
// rays are mostly aimed close to an axis through the pivot.
// ----------------------------------------------------------------------------
module tb_ray_axis_pick_core;
    import rap_pkg::*;

    localparam logic [1:0] ModeRotate = 2'd1;
    localparam logic [1:0] ModeScale = 2'd2;
    localparam logic [1:0] ModeSpare = 2'd3;
    localparam int PhaseItems = 200;
    localparam int Phases = 6;
    localparam int QuietItems = 150;
    localparam int CycleLimit = 200000;
    localparam logic [31:0] One = 32'h0001_0000;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [191:0]        s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_addr;
    logic [CfgDataW-1:0] cfg_wdata;
    int                  errors;

    bit          quiet;
    int          rays_sent;
    int          picks_seen = 0;
    int          stall_left;
    int          cycles = 0;
    logic [31:0] piv [3];

    ray_axis_pick_core dut (.*);

    rap_pick_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_axis_tready <= 1'b1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) picks_seen <= picks_seen + 1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [191:0] pack_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
        return {dz, dy, dx, oz, oy, ox};
    endfunction

    // origin = point on axis k + small offset - t * direction
    function automatic logic [191:0] aimed_ray(int k);
        logic [31:0] o [3];
        logic [31:0] d [3];
        int t;
        t = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            d[i] = 32'($signed($urandom_range(0, 2 * 131072)) - 131072);
            o[i] = piv[i] + 32'($signed($urandom_range(0, 14000)) - 7000)
                   - 32'(t) * d[i];
        end
        o[k] = o[k] + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    // direction nearly along axis k
    function automatic logic [191:0] parallel_ray(int k);
        logic [31:0] d [3];
        for (int i = 0; i < 3; i++) d[i] = 32'($signed($urandom_range(0, 1400)) - 700);
        d[k] = $urandom();
        return pack_ray(piv[0] + 32'($urandom_range(0, 9000)), piv[1], piv[2],
                        d[0], d[1], d[2]);
    endfunction

    function automatic logic [191:0] random_ray();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic send_ray(logic [191:0] ray);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ray;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        rays_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (picks_seen != rays_sent) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_regs(logic [1:0] mode, logic [31:0] px, py, pz);
        logic [31:0] vals [4];
        vals = '{32'(mode), px, py, pz};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= CfgIdxW'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        piv = '{px, py, pz};
    endtask

    initial begin
        logic [1:0] mode;
        logic [31:0] p [3];
        int kind;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        quiet = 0;
        rays_sent = 0;
        piv = '{32'd0, 32'd0, 32'd0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_ray('0);
        send_ray({6{32'h8000_0000}});
        send_ray({6{32'h7FFF_FFFF}});
        send_ray({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
        send_ray(pack_ray(32'd0, 32'd5000, 32'd3 * One, 32'd0, 32'd0, -One));
        send_ray(pack_ray(32'd4000, 32'd0, 32'd2 * One, One, 32'd0, 32'd0));
        send_ray(pack_ray(32'd2 * One, 32'd3000, 32'd0, 32'd0, -One, 32'd0));
        send_ray(pack_ray(10 * One, 32'd16384, 32'd0, 32'd0, 3 * One, 4 * One));
        send_ray(pack_ray(10 * One, 32'd16383, 32'd0, 32'd0, 3 * One, 4 * One));
        send_ray(pack_ray(32'd100, 32'd100, 32'd100, 32'd0, 32'd0, 32'd0));
        send_ray(pack_ray(32'd0, 32'd100, 32'd0, One, 32'd300, 32'd200));
        send_ray(pack_ray(32'd0, 32'd0, 32'd0, One, One, One));
        drain();
        set_regs(ModeRotate, 32'd0, 32'd0, 32'd0);
        send_ray(pack_ray(32'd0, 32'd5000, 32'd3 * One, 32'd0, 32'd0, -One));
        drain();
        set_regs(ModeScale, 32'd0, 32'd0, 32'd0);
        send_ray(pack_ray(32'd4000, 32'd0, 32'd2 * One, One, 32'd0, 32'd0));
        drain();
        set_regs(ModeSpare, 32'd0, 32'd0, 32'd0);
        send_ray(pack_ray(32'd2 * One, 32'd3000, 32'd0, 32'd0, -One, 32'd0));
        drain();

        for (int ph = 0; ph < Phases; ph++) begin
            mode = (ph == 3) ? ModeScale : ModeTranslate;
            for (int i = 0; i < 3; i++)
                p[i] = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            if (ph == 1) p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
            if (ph == 2) p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
            if (ph == 4) p = '{$urandom(), $urandom(), $urandom()};
            set_regs(mode, p[0], p[1], p[2]);
            for (int n = 0; n < PhaseItems; n++) begin
                quiet = (ph == Phases - 1) && (n >= PhaseItems - QuietItems);
                kind = $urandom_range(0, 9);
                if (kind < 6) send_ray(aimed_ray($urandom_range(0, 2)));
                else if (kind < 8) send_ray(parallel_ray($urandom_range(0, 2)));
                else send_ray(random_ray());
            end
            drain();
        end

        if (errors == 0 && checker_i.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
